// File: rtl/lass_pkg.sv
// Shared codes, widths and types for the latent state step unit.
package lass_pkg;

  localparam int CMD_W       = 3;
  localparam int IDX_FIELD_W = 6;
  localparam int DATA_W      = 32;
  localparam int LSIZE_W     = 7;
  localparam int CSIZE_W     = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int FRAC_W      = 16;

  localparam logic [LSIZE_W-1:0] LSIZE_RESET = 7'd16;
  localparam logic [CSIZE_W-1:0] CSIZE_RESET = 3'd4;

  localparam logic [CMD_W-1:0] CMD_WR_STATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_INPUT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_BIAS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WR_LATENT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STEP      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LATENT_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_SIZE = 1'b1;

  // kind of term flowing down the multiply-accumulate pipe
  localparam logic [1:0] TERM_STATE = 2'd0;
  localparam logic [1:0] TERM_INPUT = 2'd1;
  localparam logic [1:0] TERM_BIAS  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
  } term_tag_t;

endpackage

// File: rtl/latent_affine_state_step_unit.sv
// Top level: affine latent state step z' = A z + B u + bias over coefficient and latent memories.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_stall, in_command .. in_control_3| item in
//   out     | out_valid, out_stall, out_element_index, ...  | item out
//   cfg     | cfg_we, cfg_index, cfg_wdata                  | reg write
//
// A step item runs each of the n latent rows (n latent elements, m control inputs
// in use) through the single shared multiplier, fed from one coefficient memory
// read per cycle; in_stall holds off new items until the step's last row is emitted.
// rst_n is synchronous; no clearing pass, latent entries carry valid bits.
// A stalled result holds the next row in its emit cycle until the slot frees.
module latent_affine_state_step_unit
  import lass_pkg::*;
#(
  parameter int MAX_LATENT  = 16,
  parameter int MAX_CONTROL = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [IDX_FIELD_W-1:0] in_row,
  input  logic [IDX_FIELD_W-1:0] in_col,
  input  data_t                  in_value,
  input  data_t                  in_control_0,
  input  data_t                  in_control_1,
  input  data_t                  in_control_2,
  input  data_t                  in_control_3,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IDX_FIELD_W-1:0] out_element_index,
  output data_t                  out_latent_value,
  output logic                   out_last,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W      = (MAX_LATENT > 1) ? $clog2(MAX_LATENT) : 1;
  localparam int CNT_W      = $clog2(MAX_LATENT + 1);
  localparam int MCNT_W     = $clog2(MAX_CONTROL + 1);
  localparam int JMAX       = (MAX_LATENT > MAX_CONTROL) ? MAX_LATENT : MAX_CONTROL;
  localparam int J_W        = (JMAX > 1) ? $clog2(JMAX) : 1;
  localparam int U_W        = (MAX_CONTROL > 1) ? $clog2(MAX_CONTROL) : 1;
  localparam int STRIDE     = MAX_LATENT + MAX_CONTROL + 1;
  localparam int COEF_DEPTH = MAX_LATENT * STRIDE;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int LAT_DEPTH  = 2 ** (IDX_W + 1);
  localparam int PW         = VALUE_WIDTH + DATA_W;
  localparam int ACC_W      = PW + $clog2(MAX_LATENT + MAX_CONTROL);
  localparam int SUM_W      = ACC_W - FRAC_W + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [LSIZE_W-1:0] latent_size_r;
  logic [CSIZE_W-1:0] control_size_r;

  logic [1:0]        st_r;
  logic [CNT_W-1:0]  n_r;
  logic [MCNT_W-1:0] m_r;
  logic [IDX_W-1:0]  row_r;
  logic [CA_W-1:0]   base_r;
  logic [1:0]        ph_r;
  logic [J_W-1:0]    j_r;
  logic [MAX_LATENT-1:0] bank_r;
  logic [MAX_LATENT-1:0] lvalid_r;

  data_t u_r [MAX_CONTROL];
  data_t ctl_in [4];

  logic [VALUE_WIDTH-1:0] coef_mem [COEF_DEPTH];
  logic [VALUE_WIDTH-1:0] lat_mem [LAT_DEPTH];

  logic [VALUE_WIDTH-1:0] coef_q_r;
  logic [VALUE_WIDTH-1:0] lat_q_r;
  logic                   lat_ok_r;
  data_t                  opb1_r;
  term_tag_t              tag1_r;
  term_tag_t              tag2_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [VALUE_WIDTH-1:0] bias_r;

  logic                   out_valid_r;
  logic [IDX_FIELD_W-1:0] out_element_index_r;
  data_t                  out_latent_value_r;
  logic                   out_last_r;

  logic in_acc;
  logic step_go;
  logic [CNT_W-1:0]  n_eff;
  logic [MCNT_W-1:0] m_eff;
  logic row_ok, col_ok_a, col_ok_b;
  logic [IDX_W-1:0] row_idx;
  logic             coef_we;
  logic [CA_W-1:0]  coef_woff;
  logic [CA_W-1:0]  coef_waddr;
  logic [CA_W-1:0]  coef_roff;
  logic [CA_W-1:0]  coef_raddr;
  logic [IDX_W-1:0] j_lat;
  logic [IDX_W:0]   lat_raddr;
  logic             lat_we;
  logic [IDX_W:0]   lat_waddr;
  logic [VALUE_WIDTH-1:0] lat_wdata;
  logic             slot_free;
  logic             emit_fire;
  logic             last_row;
  logic signed [VALUE_WIDTH-1:0] opa;
  data_t                  opb;
  logic signed [SUM_W-1:0] sum;
  logic                   fits;
  logic signed [VALUE_WIDTH-1:0] sat;

  assign ctl_in[0] = in_control_0;
  assign ctl_in[1] = in_control_1;
  assign ctl_in[2] = in_control_2;
  assign ctl_in[3] = in_control_3;

  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign n_eff = (latent_size_r > LSIZE_W'(MAX_LATENT)) ? CNT_W'(MAX_LATENT)
                                                          : latent_size_r[CNT_W-1:0];
  assign m_eff = (control_size_r > CSIZE_W'(MAX_CONTROL)) ? MCNT_W'(MAX_CONTROL)
                                                            : control_size_r[MCNT_W-1:0];
  assign step_go = in_acc && (in_command == CMD_STEP) && (n_eff != '0);

  // Write decode
  assign row_ok   = ({1'b0, in_row} < 7'(MAX_LATENT));
  assign col_ok_a = ({1'b0, in_col} < 7'(MAX_LATENT));
  assign col_ok_b = ({1'b0, in_col} < 7'(MAX_CONTROL));
  assign row_idx  = in_row[IDX_W-1:0];

  always_comb begin
    coef_we   = 1'b0;
    coef_woff = CA_W'(MAX_LATENT + MAX_CONTROL);
    case (in_command)
      CMD_WR_STATE: begin
        coef_we   = in_acc && row_ok && col_ok_a;
        coef_woff = CA_W'(in_col);
      end
      CMD_WR_INPUT: begin
        coef_we   = in_acc && row_ok && col_ok_b;
        coef_woff = CA_W'(MAX_LATENT) + CA_W'(in_col);
      end
      CMD_WR_BIAS: begin
        coef_we   = in_acc && row_ok;
      end
      default: begin
        coef_we   = 1'b0;
      end
    endcase
  end

  assign coef_waddr = CA_W'(row_idx) * CA_W'(STRIDE) + coef_woff;

  // Issue side: one coefficient and one latent read per cycle
  always_comb begin
    case (ph_r)
      TERM_STATE: coef_roff = CA_W'(j_r);
      TERM_INPUT: coef_roff = CA_W'(MAX_LATENT) + CA_W'(j_r);
      default:    coef_roff = CA_W'(MAX_LATENT + MAX_CONTROL);
    endcase
  end

  assign coef_raddr = base_r + coef_roff;
  assign j_lat      = j_r[IDX_W-1:0];
  assign lat_raddr  = {bank_r[j_lat], j_lat};

  // Result of the row: floor the Q32.32 sum to Q16.16, add bias, saturate
  assign sum  = SUM_W'($signed(acc_r[ACC_W-1:FRAC_W])) + SUM_W'(bias_r);
  assign fits = (&sum[SUM_W-1:VALUE_WIDTH-1]) || !(|sum[SUM_W-1:VALUE_WIDTH-1]);
  assign sat  = fits ? sum[VALUE_WIDTH-1:0]
                     : (sum[SUM_W-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(VALUE_WIDTH-1){1'b1}}});

  assign slot_free = !out_valid_r || !out_stall;
  assign emit_fire = (st_r == S_EMIT) && slot_free;
  assign last_row  = (CNT_W'(row_r) == n_r - CNT_W'(1));

  // Step results go to the other bank of their entry, so the old vector stays readable
  always_comb begin
    if (st_r == S_EMIT) begin
      lat_we    = emit_fire;
      lat_waddr = {~bank_r[row_r], row_r};
      lat_wdata = sat;
    end else begin
      lat_we    = in_acc && (in_command == CMD_WR_LATENT) && row_ok;
      lat_waddr = {bank_r[row_idx], row_idx};
      lat_wdata = in_value[VALUE_WIDTH-1:0];
    end
  end

  // Memories: writes happen only in idle or emit; both memories are read every cycle
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_value[VALUE_WIDTH-1:0];
    end
    coef_q_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (lat_we) begin
      lat_mem[lat_waddr] <= lat_wdata;
    end
    lat_q_r <= lat_mem[lat_raddr];
  end

  // Multiply stage operands
  assign opa = $signed(coef_q_r);
  assign opb = (tag1_r.kind == TERM_STATE)
             ? (lat_ok_r ? DATA_W'($signed(lat_q_r)) : '0)
             : opb1_r;

  always_ff @(posedge clk) begin
    lat_ok_r <= lvalid_r[j_lat];
    opb1_r   <= u_r[j_r[U_W-1:0]];
    prod_r   <= opa * opb;
    if (tag1_r.vld && (tag1_r.kind == TERM_BIAS)) begin
      bias_r <= opa;
    end
    if (step_go || emit_fire) begin
      acc_r <= '0;
    end else if (tag2_r.vld && (tag2_r.kind != TERM_BIAS)) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (step_go) begin
      for (int c = 0; c < MAX_CONTROL; c++) begin
        u_r[c] <= ctl_in[c];
      end
    end
    if (emit_fire) begin
      out_element_index_r <= IDX_FIELD_W'(row_r);
      out_latent_value_r  <= DATA_W'(sat);
      out_last_r          <= last_row;
    end
  end

  // Control: configuration, sequencer, pipe tags, bank bits, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latent_size_r  <= LSIZE_RESET;
      control_size_r <= CSIZE_RESET;
      st_r           <= S_IDLE;
      n_r            <= '0;
      m_r            <= '0;
      row_r          <= '0;
      base_r         <= '0;
      ph_r           <= TERM_STATE;
      j_r            <= '0;
      bank_r         <= '0;
      lvalid_r       <= '0;
      tag1_r         <= '0;
      tag2_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LATENT_SIZE:  latent_size_r  <= cfg_wdata[LSIZE_W-1:0];
          CFG_CONTROL_SIZE: control_size_r <= cfg_wdata[CSIZE_W-1:0];
          default: ;
        endcase
      end

      tag1_r.vld  <= (st_r == S_RUN);
      tag1_r.kind <= ph_r;
      tag2_r      <= tag1_r;

      if (lat_we && (st_r == S_IDLE)) begin
        lvalid_r[row_idx] <= 1'b1;
      end

      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        S_IDLE: begin
          if (step_go) begin
            st_r   <= S_RUN;
            n_r    <= n_eff;
            m_r    <= m_eff;
            row_r  <= '0;
            base_r <= '0;
            ph_r   <= TERM_STATE;
            j_r    <= '0;
          end
        end
        S_RUN: begin
          case (ph_r)
            TERM_STATE: begin
              if (CNT_W'(j_r) == n_r - CNT_W'(1)) begin
                j_r  <= '0;
                ph_r <= (m_r == '0) ? TERM_BIAS : TERM_INPUT;
              end else begin
                j_r <= j_r + J_W'(1);
              end
            end
            TERM_INPUT: begin
              if (MCNT_W'(j_r) == m_r - MCNT_W'(1)) begin
                j_r  <= '0;
                ph_r <= TERM_BIAS;
              end else begin
                j_r <= j_r + J_W'(1);
              end
            end
            default: begin
              st_r <= S_DRAIN;
            end
          endcase
        end
        S_DRAIN: begin
          // hold until the bias and the last product have left the pipe
          if (!tag1_r.vld && !tag2_r.vld) begin
            st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (last_row) begin
              st_r <= S_IDLE;
              // swap in the new vector for the elements in use
              for (int k = 0; k < MAX_LATENT; k++) begin
                if (CNT_W'(k) < n_r) begin
                  bank_r[k]   <= ~bank_r[k];
                  lvalid_r[k] <= 1'b1;
                end
              end
            end else begin
              st_r   <= S_RUN;
              row_r  <= row_r + IDX_W'(1);
              base_r <= base_r + CA_W'(STRIDE);
              ph_r   <= TERM_STATE;
              j_r    <= '0;
            end
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_index = out_element_index_r;
  assign out_latent_value  = out_latent_value_r;
  assign out_last          = out_last_r;

endmodule

// File: rtl/lass_checker.sv
// Port-level checker for the latent state step unit, bound to the top level.
module lass_checker
  import lass_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [CMD_W-1:0]       in_command,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [IDX_FIELD_W-1:0] out_element_index,
  input data_t                  out_latent_value,
  input logic                   out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element_index) &&
                               $stable(out_latent_value) && $stable(out_last))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_mid_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !out_last |-> in_stall)
    else $error("input taken while a step still has rows to emit");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_last |-> !in_stall)
    else $error("block still busy after last element of a step");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command != CMD_STEP) |=> !$rose(out_valid))
    else $error("write item produced a result");

endmodule

bind latent_affine_state_step_unit lass_checker u_lass_checker (.*);

// File: tb/tb_latent_affine_state_step_unit.sv
// Testbench for the latent state step unit: directed and random items checked against a predictor.
module tb_latent_affine_state_step_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lass_pkg::*;

  localparam int LATENT_CAP    = 16;
  localparam int CONTROL_CAP   = 4;
  localparam int SETTLE_CYCLES = 420;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam data_t VALUE_MAX = 32'sh7FFF_FFFF;
  localparam data_t VALUE_MIN = 32'sh8000_0000;
  localparam data_t VALUE_ONE = 32'sh0001_0000;
  localparam logic signed [63:0] SAT_HIGH = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LOW  = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] index;
    data_t                  value;
    logic                   last;
  } latent_out_t;

  class latent_step_scoreboard;
    data_t state_coef [LATENT_CAP*LATENT_CAP];
    data_t input_coef [LATENT_CAP*CONTROL_CAP];
    data_t bias_vec   [LATENT_CAP];
    data_t latent_vec [LATENT_CAP];
    logic [LSIZE_W-1:0] latent_size;
    logic [CSIZE_W-1:0] control_size;
    latent_out_t pending [$];
    int failures;

    function new();
      foreach (state_coef[k]) state_coef[k] = '0;
      foreach (input_coef[k]) input_coef[k] = '0;
      foreach (bias_vec[k]) bias_vec[k] = '0;
      foreach (latent_vec[k]) latent_vec[k] = '0;
      latent_size  = LSIZE_RESET;
      control_size = CSIZE_RESET;
      failures     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_LATENT_SIZE) begin
        latent_size = data[LSIZE_W-1:0];
      end else begin
        control_size = data[CSIZE_W-1:0];
      end
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [IDX_FIELD_W-1:0] row,
                            logic [IDX_FIELD_W-1:0] col, data_t value,
                            data_t c0, data_t c1, data_t c2, data_t c3);
      int n, m, i, j;
      data_t ctrl  [CONTROL_CAP];
      data_t fresh [LATENT_CAP];
      logic signed [63:0] prod, hi, lo, bias_w, tot;
      latent_out_t res;
      case (cmd)
        CMD_WR_STATE: begin
          if (row < LATENT_CAP && col < LATENT_CAP) state_coef[row*LATENT_CAP+col] = value;
        end
        CMD_WR_INPUT: begin
          if (row < LATENT_CAP && col < CONTROL_CAP) input_coef[row*CONTROL_CAP+col] = value;
        end
        CMD_WR_BIAS: begin
          if (row < LATENT_CAP) bias_vec[row] = value;
        end
        CMD_WR_LATENT: begin
          if (row < LATENT_CAP) latent_vec[row] = value;
        end
        CMD_STEP: begin
          n = (latent_size > LATENT_CAP) ? LATENT_CAP : int'(latent_size);
          m = (control_size > CONTROL_CAP) ? CONTROL_CAP : int'(control_size);
          ctrl[0] = c0;
          ctrl[1] = c1;
          ctrl[2] = c2;
          ctrl[3] = c3;
          for (i = 0; i < n; i++) begin
            hi = '0;
            lo = '0;
            // exact Q32.32 products; keep the fraction bits apart so no carry is lost
            for (j = 0; j < n + m; j++) begin
              if (j < n) prod = state_coef[i*LATENT_CAP+j] * latent_vec[j];
              else prod = input_coef[i*CONTROL_CAP+j-n] * ctrl[j-n];
              hi = hi + (prod >>> 16);
              lo = lo + {48'd0, prod[15:0]};
            end
            bias_w = bias_vec[i];
            tot = hi + (lo >>> 16) + bias_w;
            if (tot > SAT_HIGH) fresh[i] = VALUE_MAX;
            else if (tot < SAT_LOW) fresh[i] = VALUE_MIN;
            else fresh[i] = tot[31:0];
          end
          for (i = 0; i < n; i++) begin
            latent_vec[i] = fresh[i];
            res.index = IDX_FIELD_W'(i);
            res.value = fresh[i];
            res.last  = (i == n - 1);
            pending.insert(pending.size(), res);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [IDX_FIELD_W-1:0] idx, data_t val, logic last_flag);
      latent_out_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: index %0d value %h last %b", idx, val, last_flag);
        return;
      end
      want = pending.pop_front();
      if (want.index !== idx || want.value !== val || want.last !== last_flag) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: index exp %0d got %0d, value exp %h got %h, last exp %b got %b",
                   want.index, idx, want.value, val, want.last, last_flag);
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [CMD_W-1:0]       in_command   = CMD_WR_STATE;
  logic [IDX_FIELD_W-1:0] in_row       = '0;
  logic [IDX_FIELD_W-1:0] in_col       = '0;
  data_t                  in_value     = '0;
  data_t                  in_control_0 = '0;
  data_t                  in_control_1 = '0;
  data_t                  in_control_2 = '0;
  data_t                  in_control_3 = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [IDX_FIELD_W-1:0] out_element_index;
  data_t                  out_latent_value;
  logic                   out_last;
  logic                   cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index    = CFG_LATENT_SIZE;
  logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;

  latent_step_scoreboard sb = new();
  bit quiet = 1'b0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  latent_affine_state_step_unit #(
    .MAX_LATENT  (LATENT_CAP),
    .MAX_CONTROL (CONTROL_CAP),
    .VALUE_WIDTH (32)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .in_control_0      (in_control_0),
    .in_control_1      (in_control_1),
    .in_control_2      (in_control_2),
    .in_control_3      (in_control_3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_index (out_element_index),
    .out_latent_value  (out_latent_value),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // both channels observed at the edge where the handshake completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_element_index, out_latent_value, out_last);
      if (in_valid && !in_stall)
        sb.note_item(in_command, in_row, in_col, in_value,
                     in_control_0, in_control_1, in_control_2, in_control_3);
    end
  end

  // result side: stall a random number of cycles per item, with calm stretches
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    forever begin
      hold = ((taken % 48) >= 36) ? 0 : $urandom_range(0, 5);
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
      taken++;
    end
  end

  function automatic data_t pick_value();
    data_t v;
    case ($urandom_range(0, 9))
      0: v = VALUE_MAX;
      1: v = VALUE_MIN;
      2, 3: v = $urandom;
      default: begin
        v = $urandom_range(0, 131072);
        v = v - VALUE_ONE;
      end
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_FIELD_W-1:0] row,
                           input logic [IDX_FIELD_W-1:0] col, input data_t value,
                           input data_t c0, input data_t c1, input data_t c2, input data_t c3);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_row       <= row;
    in_col       <= col;
    in_value     <= value;
    in_control_0 <= c0;
    in_control_1 <= c1;
    in_control_2 <= c2;
    in_control_3 <= c3;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_write(input logic [CMD_W-1:0] cmd, input logic [IDX_FIELD_W-1:0] row,
                            input logic [IDX_FIELD_W-1:0] col, input data_t value);
    send_item(cmd, row, col, value, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_step(input data_t c0, input data_t c1, input data_t c2, input data_t c3);
    send_item(CMD_STEP, IDX_FIELD_W'($urandom), IDX_FIELD_W'($urandom), $urandom,
              c0, c1, c2, c3);
  endtask

  // drop valid and hold until every expected item has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_sizes(input logic [CFG_DATA_W-1:0] ls, input logic [CSIZE_W-1:0] cs);
    logic [CFG_DATA_W-1:0] cs_word;
    cs_word = {(CFG_DATA_W-CSIZE_W)'($urandom), cs};
    hold_until_drained();
    // margin before the sizes change; a step with no results never starts
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LATENT_SIZE;
    cfg_wdata <= ls;
    @(posedge clk);
    cfg_index <= CFG_CONTROL_SIZE;
    cfg_wdata <= cs_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_LATENT_SIZE, ls);
    sb.set_reg(CFG_CONTROL_SIZE, cs_word);
  endtask

  task automatic preload_coefficients();
    int r, c;
    data_t v;
    for (r = 0; r < LATENT_CAP; r++) begin
      for (c = 0; c < LATENT_CAP; c++) begin
        v = $urandom_range(0, 8192);
        send_write(CMD_WR_STATE, IDX_FIELD_W'(r), IDX_FIELD_W'(c), v - 32'sd4096);
      end
      for (c = 0; c < CONTROL_CAP; c++) begin
        v = $urandom_range(0, 65536);
        send_write(CMD_WR_INPUT, IDX_FIELD_W'(r), IDX_FIELD_W'(c), v - 32'sd32768);
      end
      v = $urandom_range(0, 131072);
      send_write(CMD_WR_BIAS, IDX_FIELD_W'(r), IDX_FIELD_W'($urandom), v - VALUE_ONE);
    end
  endtask

  task automatic run_directed();
    int k;
    send_write(CMD_WR_STATE, IDX_FIELD_W'(0), IDX_FIELD_W'(0), VALUE_MAX);
    send_write(CMD_WR_STATE, IDX_FIELD_W'(0), IDX_FIELD_W'(1), VALUE_MIN);
    send_write(CMD_WR_INPUT, IDX_FIELD_W'(0), IDX_FIELD_W'(0), VALUE_MAX);
    send_write(CMD_WR_INPUT, IDX_FIELD_W'(LATENT_CAP - 1), IDX_FIELD_W'(CONTROL_CAP - 1),
               VALUE_MIN);
    send_write(CMD_WR_BIAS, IDX_FIELD_W'(0), IDX_FIELD_W'(0), VALUE_MAX);
    send_write(CMD_WR_BIAS, IDX_FIELD_W'(LATENT_CAP - 1), IDX_FIELD_W'(0), VALUE_MIN);
    send_write(CMD_WR_LATENT, IDX_FIELD_W'(0), IDX_FIELD_W'(0), VALUE_MAX);
    send_write(CMD_WR_LATENT, IDX_FIELD_W'(1), IDX_FIELD_W'(0), VALUE_MIN);
    send_write(CMD_WR_LATENT, IDX_FIELD_W'(LATENT_CAP - 1), IDX_FIELD_W'(0), VALUE_ONE);
    send_step(VALUE_MAX, VALUE_MIN, '0, '1);
    // writes out of range leave the stores alone
    send_write(CMD_WR_STATE, IDX_FIELD_W'(LATENT_CAP), IDX_FIELD_W'(0), VALUE_MAX);
    send_write(CMD_WR_STATE, IDX_FIELD_W'(0), IDX_FIELD_W'(63), VALUE_MAX);
    send_write(CMD_WR_INPUT, IDX_FIELD_W'(3), IDX_FIELD_W'(CONTROL_CAP), VALUE_MIN);
    send_write(CMD_WR_INPUT, IDX_FIELD_W'(63), IDX_FIELD_W'(7), VALUE_MIN);
    send_write(CMD_WR_BIAS, IDX_FIELD_W'(LATENT_CAP), IDX_FIELD_W'(0), VALUE_MAX);
    send_write(CMD_WR_LATENT, IDX_FIELD_W'(63), IDX_FIELD_W'(63), VALUE_MIN);
    for (k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
      send_write(CMD_W'(k), IDX_FIELD_W'(63), IDX_FIELD_W'(63), VALUE_MIN);
    send_step('0, '0, '0, '0);
    send_write(CMD_WR_STATE, IDX_FIELD_W'(0), IDX_FIELD_W'(0), VALUE_ONE);
    send_write(CMD_WR_STATE, IDX_FIELD_W'(0), IDX_FIELD_W'(1), '0);
    send_write(CMD_WR_LATENT, IDX_FIELD_W'(0), IDX_FIELD_W'(0), '0);
    send_step(pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  task automatic send_random(output bit took);
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [IDX_FIELD_W-1:0] row, col;
    pick = $urandom_range(0, 99);
    row  = IDX_FIELD_W'($urandom_range(0, LATENT_CAP - 1));
    col  = IDX_FIELD_W'($urandom);
    took = 1'b1;
    if (pick < 30) begin
      cmd = CMD_STEP;
    end else if (pick < 50) begin
      cmd = CMD_WR_STATE;
      col = IDX_FIELD_W'($urandom_range(0, LATENT_CAP - 1));
    end else if (pick < 60) begin
      cmd = CMD_WR_INPUT;
      col = IDX_FIELD_W'($urandom_range(0, CONTROL_CAP - 1));
    end else if (pick < 68) begin
      cmd = CMD_WR_BIAS;
    end else if (pick < 85) begin
      cmd = CMD_WR_LATENT;
    end else if (pick < 93) begin
      // writes anywhere, mostly out of range
      cmd  = CMD_W'($urandom_range(CMD_WR_STATE, CMD_WR_LATENT));
      row  = IDX_FIELD_W'($urandom);
      took = 1'b0;
    end else begin
      cmd  = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      row  = IDX_FIELD_W'($urandom);
      took = 1'b0;
    end
    send_item(cmd, row, col, pick_value(),
              pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] ls, input logic [CSIZE_W-1:0] cs,
                           input bit calm, input int target);
    int counted, k;
    bit took, paused;
    set_sizes(ls, cs);
    counted = 0;
    k       = 0;
    paused  = 1'b0;
    while (counted < target) begin
      quiet = calm || ((k % 32) >= 24);
      if (!paused && counted == target / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      send_random(took);
      if (took) counted++;
      k++;
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    preload_coefficients();
    run_directed();
    run_phase(CFG_DATA_W'(1), CSIZE_W'(1), 1'b0, 40);
    run_phase(CFG_DATA_W'(0), CSIZE_W'(4), 1'b0, 15);
    run_phase(CFG_DATA_W'(16), CSIZE_W'(0), 1'b0, 45);
    run_phase(CFG_DATA_W'(64), CSIZE_W'(7), 1'b1, 40);
    run_phase(CFG_DATA_W'(127), CSIZE_W'(5), 1'b0, 45);
    run_phase(CFG_DATA_W'(4), CSIZE_W'(2), 1'b0, 50);
    run_phase(CFG_DATA_W'(16), CSIZE_W'(4), 1'b0, 50);
    run_phase(CFG_DATA_W'($urandom_range(1, LATENT_CAP)), CSIZE_W'($urandom_range(0, 4)),
              1'b0, 85);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lass_pkg.sv
rtl/latent_affine_state_step_unit.sv
rtl/lass_checker.sv
tb/tb_latent_affine_state_step_unit.sv
